// ===== design/edge_plane_crossing_top_assert.svh =====
// assertion macros for the edge plane crossing block
// used by edge_plane_crossing_top only
`ifndef EDGE_PLANE_CROSSING_TOP_ASSERT_SVH
`define EDGE_PLANE_CROSSING_TOP_ASSERT_SVH
// a condition that must hold in the cycle after a trigger
`define EPC_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);
// a condition that must hold in the same cycle
`define EPC_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) else $error(msg);
`endif

// ===== design/epc_pkg.sv =====
// shared types and constants for the edge plane crossing block
// no dependencies
`timescale 1ns / 1ps
package epc_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned IdxW   = 32;
  localparam int unsigned DistW  = 67;
  localparam int unsigned TW     = 17;
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_PX = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PY = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PZ = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_NX = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_NY = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_NZ = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_VC = 3'd6;
  // pipeline depth: 3 front stages, 17 divide steps, 2 lerp stages
  localparam int unsigned Depth = 22;
  typedef struct packed {
    logic signed [CoordW-1:0] ax, ay, az, bx, by, bz;
    logic [IdxW-1:0] lo, hi;
  } edge_t;
endpackage

// ===== design/edge_plane_crossing_top.sv =====
// edge plane crossing top level: 22 stage pipelined datapath
// depends on epc_pkg, epc_div_step and edge_plane_crossing_top_assert.svh
//
// channel | direction | handshake
// in_     | input     | in_valid / in_ready
// out_    | output    | out_valid / out_ready
// cfg_    | input     | cfg_we, no wait
//
// one edge enters per cycle while the output is not stalled
// stages: difference, products, distance sum, 17 divide steps, two lerp stages
// a stalled output freezes the whole pipe and holds in_ready low until it is taken
// reset is synchronous, active low, and clears valid bits and the plane registers but sets normal z to 65536
`timescale 1ns / 1ps
`include "edge_plane_crossing_top_assert.svh"
module edge_plane_crossing_top (
  input  logic clk,
  input  logic rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_start_index,
  input  logic [31:0] in_end_index,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_start_z,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  input  logic signed [31:0] in_end_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic signed [31:0] out_cross_x,
  output logic signed [31:0] out_cross_y,
  output logic signed [31:0] out_cross_z,
  output logic [31:0] out_edge_low,
  output logic [31:0] out_edge_high
);
  localparam int unsigned D = epc_pkg::Depth;
  localparam int unsigned DW = epc_pkg::DistW;
  localparam int unsigned NDIV = 17;

  logic signed [31:0] px_r, py_r, pz_r, nx_r, ny_r, nz_r;
  logic [31:0] vc_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0; py_r <= '0; pz_r <= '0;
      nx_r <= '0; ny_r <= '0; nz_r <= 32'sd65536;
      vc_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        epc_pkg::REG_PX: px_r <= cfg_data;
        epc_pkg::REG_PY: py_r <= cfg_data;
        epc_pkg::REG_PZ: pz_r <= cfg_data;
        epc_pkg::REG_NX: nx_r <= cfg_data;
        epc_pkg::REG_NY: ny_r <= cfg_data;
        epc_pkg::REG_NZ: nz_r <= cfg_data;
        epc_pkg::REG_VC: vc_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipe advances unless the last stage holds a result that is not taken
  logic adv;
  logic [D-1:0] v_r;
  assign adv = !v_r[D-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = v_r[D-1];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[D-2:0], in_valid};
  end

  // edge payload and "still a candidate" flag travel with each stage
  epc_pkg::edge_t e_r [D];
  logic ok_r [D];

  // stage 0: differences, index check, key
  logic signed [32:0] dax_r, day_r, daz_r, dbx_r, dby_r, dbz_r;
  // stage 1: products
  logic signed [63:0] pax_r, pay_r, paz_r, pbx_r, pby_r, pbz_r;
  // stage 2: distances
  logic signed [DW-1:0] da_r, db_r;
  // divider stages
  logic [DW:0] n_r [NDIV];
  logic [DW:0] dd_r [NDIV];
  logic [epc_pkg::TW-1:0] q_r [NDIV];
  // lerp stages
  logic signed [49:0] mx_r, my_r, mz_r;
  logic signed [31:0] cx_r, cy_r, cz_r;

  logic ok0;
  epc_pkg::edge_t e0;
  always_comb begin
    e0.ax = in_start_x; e0.ay = in_start_y; e0.az = in_start_z;
    e0.bx = in_end_x;   e0.by = in_end_y;   e0.bz = in_end_z;
    e0.lo = (in_start_index < in_end_index) ? in_start_index : in_end_index;
    e0.hi = (in_start_index < in_end_index) ? in_end_index : in_start_index;
    ok0 = (in_start_index < vc_r) && (in_end_index < vc_r)
          && !(nx_r == 0 && ny_r == 0 && nz_r == 0);
  end

  logic [DW-1:0] ma, mb;
  logic za, zb, sa, sb, hit2;
  always_comb begin
    za = da_r == 0; zb = db_r == 0;
    sa = da_r[DW-1]; sb = db_r[DW-1];
    hit2 = ok_r[2] && !(za && zb) && !(!za && !zb && sa == sb);
    ma = sa ? DW'(-da_r) : DW'(da_r);
    mb = sb ? DW'(-db_r) : DW'(db_r);
  end

  logic [DW:0] n_nx [NDIV];
  logic [epc_pkg::TW-1:0] q_nx [NDIV];
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    epc_div_step u_step (
      .n_i     (k == 0 ? {1'b0, ma} : n_r[k == 0 ? 0 : k-1]),
      .d_i     (k == 0 ? ({1'b0, ma} + {1'b0, mb}) : dd_r[k == 0 ? 0 : k-1]),
      .q_i     (k == 0 ? epc_pkg::TW'(0) : q_r[k == 0 ? 0 : k-1]),
      .shift_i (k != 0),
      .n_o     (n_nx[k]),
      .q_o     (q_nx[k])
    );
  end

  localparam int unsigned SD = 3 + NDIV; // lerp multiply stage index
  logic [epc_pkg::TW-1:0] tq;
  assign tq = q_r[NDIV-1];

  function automatic logic signed [31:0] lerp_fin(input logic signed [31:0] a,
                                                 input logic signed [49:0] p);
    logic signed [49:0] off;
    begin
      off = p >>> 16; // arithmetic shift is floor
      lerp_fin = a + off[31:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      e_r[0] <= e0; ok_r[0] <= ok0;
      dax_r <= 33'(e0.ax) - 33'(px_r); day_r <= 33'(e0.ay) - 33'(py_r);
      daz_r <= 33'(e0.az) - 33'(pz_r); dbx_r <= 33'(e0.bx) - 33'(px_r);
      dby_r <= 33'(e0.by) - 33'(py_r); dbz_r <= 33'(e0.bz) - 33'(pz_r);
      // stage 3 takes the crossing decision instead of the plain candidate flag
      for (int s = 1; s < D; s++) begin
        e_r[s] <= e_r[s-1];
        ok_r[s] <= (s == 3) ? hit2 : ok_r[s-1];
      end
      pax_r <= 64'(dax_r * nx_r); pay_r <= 64'(day_r * ny_r); paz_r <= 64'(daz_r * nz_r);
      pbx_r <= 64'(dbx_r * nx_r); pby_r <= 64'(dby_r * ny_r); pbz_r <= 64'(dbz_r * nz_r);
      da_r <= DW'(pax_r) + DW'(pay_r) + DW'(paz_r);
      db_r <= DW'(pbx_r) + DW'(pby_r) + DW'(pbz_r);
      for (int k = 0; k < NDIV; k++) begin
        n_r[k] <= n_nx[k];
        q_r[k] <= q_nx[k];
        dd_r[k] <= (k == 0) ? ({1'b0, ma} + {1'b0, mb}) : dd_r[k == 0 ? 0 : k-1];
      end
      mx_r <= 50'(e_r[SD-1].bx - 50'(e_r[SD-1].ax)) * $signed({1'b0, tq});
      my_r <= 50'(e_r[SD-1].by - 50'(e_r[SD-1].ay)) * $signed({1'b0, tq});
      mz_r <= 50'(e_r[SD-1].bz - 50'(e_r[SD-1].az)) * $signed({1'b0, tq});
      cx_r <= lerp_fin(e_r[SD].ax, mx_r);
      cy_r <= lerp_fin(e_r[SD].ay, my_r);
      cz_r <= lerp_fin(e_r[SD].az, mz_r);
    end
  end

  logic h;
  assign h = ok_r[D-1];
  assign out_hit = h;
  assign out_cross_x = h ? cx_r : '0;
  assign out_cross_y = h ? cy_r : '0;
  assign out_cross_z = h ? cz_r : '0;
  assign out_edge_low = h ? e_r[D-1].lo : '0;
  assign out_edge_high = h ? e_r[D-1].hi : '0;

  `EPC_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid, "result dropped during stall")
  `EPC_ASSERT_NOW(a_ready_free, !out_valid, in_ready, "pipe stalled with empty output")
  `EPC_ASSERT_NOW(a_key_order, out_valid, out_edge_low <= out_edge_high, "edge key out of order")
endmodule

// ===== design/epc_div_step.sv =====
// one restoring division step of the t ratio
// depends on epc_pkg
`timescale 1ns / 1ps
module epc_div_step (
  input  logic [epc_pkg::DistW:0]   n_i,
  input  logic [epc_pkg::DistW:0]   d_i,
  input  logic [epc_pkg::TW-1:0]    q_i,
  input  logic                      shift_i,
  output logic [epc_pkg::DistW:0]   n_o,
  output logic [epc_pkg::TW-1:0]    q_o
);
  logic [epc_pkg::DistW+1:0] ns;
  logic ge;
  always_comb begin
    ns = shift_i ? {n_i, 1'b0} : {1'b0, n_i};
    ge = ns >= {1'b0, d_i};
    n_o = ge ? (ns[epc_pkg::DistW:0] - d_i) : ns[epc_pkg::DistW:0];
    q_o = {q_i[epc_pkg::TW-2:0], ge};
  end
endmodule

// ===== verif/tb.sv =====
// testbench for edge_plane_crossing_top: plane crossing of streamed mesh edges
// holds its own bit-exact predictor and a small scoreboard class; needs epc_pkg
`timescale 1ns / 1ps
module tb;

  typedef struct {
    logic        hit;
    logic [31:0] cx, cy, cz, lo, hi;
  } crossing_t;

  int mismatches = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("error at %0t: %s got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // plane registers as the block should hold them
  logic signed [31:0] pl_p [3];
  logic signed [31:0] pl_n [3];
  logic [31:0]        vcount;

  // exact signed distance scaled by the normal
  function automatic logic signed [69:0] plane_dist(input logic signed [31:0] p [3]);
    logic signed [69:0] acc;
    logic signed [32:0] d;
    acc = 0;
    for (int k = 0; k < 3; k++) begin
      d = 33'(p[k]) - 33'(pl_p[k]);
      acc += 70'(d) * 70'(pl_n[k]);
    end
    return acc;
  endfunction

  // a + floor((b - a) * t / 65536)
  function automatic logic [31:0] interp(input logic signed [31:0] a, input logic signed [31:0] b,
                                         input logic [16:0] t);
    logic signed [63:0] prod;
    prod = (64'(b) - 64'(a)) * $signed({47'd0, t});
    return 32'(64'(a) + (prod >>> 16));
  endfunction

  function automatic crossing_t predict_crossing(input logic [31:0] ia, input logic [31:0] ib,
                                                 input logic signed [31:0] a [3],
                                                 input logic signed [31:0] b [3]);
    crossing_t r;
    logic signed [69:0] da, db;
    logic [69:0] ma, mb;
    logic [90:0] num;
    logic [16:0] t;
    r = '{default: 0};
    if (ia >= vcount || ib >= vcount) return r;
    if (pl_n[0] == 0 && pl_n[1] == 0 && pl_n[2] == 0) return r;
    da = plane_dist(a);
    db = plane_dist(b);
    if (da == 0 && db == 0) return r;
    if (da != 0 && db != 0 && (da < 0) == (db < 0)) return r;
    ma = da < 0 ? -da : da;
    mb = db < 0 ? -db : db;
    num = {ma, 16'd0};
    t = 17'(num / (91'(ma) + 91'(mb)));
    r.hit = 1;
    r.cx = interp(a[0], b[0], t);
    r.cy = interp(a[1], b[1], t);
    r.cz = interp(a[2], b[2], t);
    r.lo = ia < ib ? ia : ib;
    r.hi = ia < ib ? ib : ia;
    return r;
  endfunction

  class crossing_board;
    crossing_t pending[$];
    function void note_edge(input crossing_t c);
      pending.insert(pending.size(), c);
    endfunction
    task check_crossing(input crossing_t got);
      crossing_t w;
      if (pending.size() == 0) begin
        report("unexpected transfer hit", 32'(got.hit), 0);
        return;
      end
      w = pending.pop_front();
      if (got.hit !== w.hit) report("hit", 32'(got.hit), 32'(w.hit));
      if (got.cx !== w.cx) report("cross_x", got.cx, w.cx);
      if (got.cy !== w.cy) report("cross_y", got.cy, w.cy);
      if (got.cz !== w.cz) report("cross_z", got.cz, w.cz);
      if (got.lo !== w.lo) report("edge_low", got.lo, w.lo);
      if (got.hi !== w.hi) report("edge_high", got.hi, w.hi);
    endtask
  endclass

  crossing_board board = new();

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = epc_pkg::REG_PX;
  logic [31:0] cfg_data = 0;
  logic in_valid = 0, in_ready;
  logic [31:0] in_start_index = 0, in_end_index = 0;
  logic signed [31:0] in_start_x = 0, in_start_y = 0, in_start_z = 0;
  logic signed [31:0] in_end_x = 0, in_end_y = 0, in_end_z = 0;
  logic out_valid, out_ready = 0, out_hit;
  logic signed [31:0] out_cross_x, out_cross_y, out_cross_z;
  logic [31:0] out_edge_low, out_edge_high;

  edge_plane_crossing_top uut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // idling odds in percent, changed per phase
  int send_idle = 0, recv_stall = 0;

  // receiver: stall decided at each falling edge, transfers checked at the rising edge
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_crossing('{out_hit, out_cross_x, out_cross_y, out_cross_z,
                             out_edge_low, out_edge_high});
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      epc_pkg::REG_PX: pl_p[0] = val;
      epc_pkg::REG_PY: pl_p[1] = val;
      epc_pkg::REG_PZ: pl_p[2] = val;
      epc_pkg::REG_NX: pl_n[0] = val;
      epc_pkg::REG_NY: pl_n[1] = val;
      epc_pkg::REG_NZ: pl_n[2] = val;
      epc_pkg::REG_VC: vcount = val;
      default: ;
    endcase
  endtask

  // send one edge, holding valid until the transfer
  // entered and left at a falling edge; valid stays high so edges can follow back to back
  task automatic send_edge(input logic [31:0] ia, input logic [31:0] ib,
                           input logic signed [31:0] a [3], input logic signed [31:0] b [3]);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_start_index <= ia; in_end_index <= ib;
    in_start_x <= a[0]; in_start_y <= a[1]; in_start_z <= a[2];
    in_end_x <= b[0]; in_end_y <= b[1]; in_end_z <= b[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_edge(predict_crossing(ia, ib, a, b));
    @(negedge clk);
  endtask

  // let the pipe drain before touching the plane registers
  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (epc_pkg::Depth + 8) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(20 * 65536)) - 10 * 65536);
      default: return 32'($signed($urandom_range(8)) - 4) <<< 16;
    endcase
  endfunction

  // random plane with a chosen spread of magnitudes
  task automatic random_plane(input int mode);
    write_reg(epc_pkg::REG_PX, rand_coord(mode));
    write_reg(epc_pkg::REG_PY, rand_coord(mode));
    write_reg(epc_pkg::REG_PZ, rand_coord(mode));
    write_reg(epc_pkg::REG_NX, rand_coord(mode));
    write_reg(epc_pkg::REG_NY, rand_coord(mode));
    write_reg(epc_pkg::REG_NZ, rand_coord(mode));
    write_reg(epc_pkg::REG_VC, $urandom_range(3) == 0 ? $urandom : $urandom_range(1000, 1));
  endtask

  task automatic random_edges(input int n, input int mode);
    logic signed [31:0] a [3], b [3];
    logic [31:0] ia, ib;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 3; k++) begin
        a[k] = rand_coord(mode);
        b[k] = rand_coord(mode);
      end
      // mostly straddle the plane by mirroring one endpoint through the plane point
      if ($urandom_range(3) != 0)
        for (int k = 0; k < 3; k++) b[k] = 2 * pl_p[k] - a[k] + 32'($urandom_range(7)) - 3;
      if ($urandom_range(9) == 0) a = pl_p;
      if ($urandom_range(9) == 0) b = pl_p;
      ia = $urandom_range(9) == 0 ? $urandom : $urandom_range(vcount == 0 ? 0 : vcount - 1);
      ib = $urandom_range(9) == 0 ? $urandom : $urandom_range(vcount == 0 ? 0 : vcount - 1);
      send_edge(ia, ib, a, b);
    end
  endtask

  initial begin
    logic signed [31:0] a [3], b [3];
    pl_p = '{0, 0, 0};
    pl_n = '{0, 0, 65536};
    vcount = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: reset plane z = 0 with no vertices, then a small mesh
    a = '{0, 0, -65536}; b = '{0, 0, 65536};
    send_edge(0, 1, a, b);
    drain();
    write_reg(epc_pkg::REG_VC, 10);
    send_edge(3, 1, a, b);
    send_edge(10, 1, a, b);
    send_edge(1, 32'hffff_ffff, a, b);
    a = '{32'h7fff_ffff, 32'h8000_0000, 0}; b = '{32'h8000_0000, 32'h7fff_ffff, 65536};
    send_edge(2, 2, a, b);
    b = '{5, 6, 0};
    send_edge(4, 5, b, a);
    a = '{1, 2, 0};
    send_edge(6, 7, a, b);
    a = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    b = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    send_edge(9, 0, a, b);
    send_edge(0, 9, b, a);
    a = '{0, 0, 3}; b = '{9, 9, 7};
    send_edge(8, 8, a, b);
    drain();
    // extreme plane: largest magnitudes everywhere
    write_reg(epc_pkg::REG_PX, 32'h8000_0000);
    write_reg(epc_pkg::REG_PY, 32'h7fff_ffff);
    write_reg(epc_pkg::REG_PZ, 32'h8000_0000);
    write_reg(epc_pkg::REG_NX, 32'h8000_0000);
    write_reg(epc_pkg::REG_NY, 32'h8000_0000);
    write_reg(epc_pkg::REG_NZ, 32'h7fff_ffff);
    write_reg(epc_pkg::REG_VC, 32'hffff_ffff);
    a = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    b = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
    send_edge(32'hffff_fffe, 0, a, b);
    send_edge(0, 32'hffff_fffe, b, a);
    send_edge(1, 2, pl_p, a);
    drain();
    // zero normal never hits
    write_reg(epc_pkg::REG_NX, 0);
    write_reg(epc_pkg::REG_NY, 0);
    write_reg(epc_pkg::REG_NZ, 0);
    send_edge(1, 2, a, b);
    drain();

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 76; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 76; end
        default: begin send_idle = 28; recv_stall = 28; end
      endcase
      random_plane(ph % 3);
      random_edges(100, ph % 3);
      send_idle = 0; recv_stall = 0;
      drain();
    end

    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
